/* hdl/pcsd_pkg.sv */
package pcsd_pkg;

  localparam int PC_WIDTH = 32;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  task_t;
  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  cfg_idx_t;

  typedef enum logic [1:0] {
    CFG_ISA_ENABLE       = 2'd0,
    CFG_ISA_RANGE_LOW    = 2'd1,
    CFG_ISA_RANGE_HIGH   = 2'd2,
    CFG_ISA_TASK_SRC_VLD = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DECIDE,
    ST_REP_MARK,
    ST_REP_VAR,
    ST_DIFF_VAR,
    ST_TID_VAR
  } state_t;

  localparam byte_t FINAL_MARK   = 8'h80;
  localparam word_t ISA_TID_BASE = 32'd100000;
  localparam word_t PC_MASK      = (PC_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                   32'((64'd1 << PC_WIDTH) - 64'd1);

endpackage

/* hdl/pcsd_sample_if.sv */
interface pcsd_sample_if;
  import pcsd_pkg::*;

  logic  valid;
  logic  ready;
  word_t pc;
  word_t thread_id;
  task_t isa_task;

  modport source (output valid, output pc, output thread_id, output isa_task, input ready);
  modport sink (input valid, input pc, input thread_id, input isa_task, output ready);
endinterface

/* hdl/pcsd_byte_if.sv */
interface pcsd_byte_if;
  import pcsd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

/* hdl/pc_sample_delta_compressor.sv */
// Flow: a sample passes the classify and decide states, then its encoded bytes
// (1 to 16 bytes) go out; a repeated sample ends after the decide state.
// Throughput: samples are taken only in idle, one at a time; the shared 7-bit group
// shifter yields one byte a cycle, and the output register stalls it on backpressure.
// Reset (rst, synchronous, active high) clears the range registers, the PC/thread
// history, the repeat count, the sequencer and the output valid.
module pc_sample_delta_compressor (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  pcsd_pkg::cfg_idx_t cfg_index,
  input  pcsd_pkg::word_t    cfg_data,
  pcsd_sample_if.sink        sample,
  pcsd_byte_if.source        stream
);
  import pcsd_pkg::*;

  logic   isa_enable;
  word_t  isa_range_low;
  word_t  isa_range_high;
  logic   isa_task_source_valid;

  state_t state, state_next;
  word_t  pc_q, os_tid_q, tid_q, diff_q;
  task_t  task_q;
  word_t  last_pc, last_thread, repeat_count;
  logic   thread_chg;
  word_t  work, work_next;

  logic   out_valid;
  byte_t  out_byte_q;
  logic   out_last_q;

  logic   accept, adv, in_range, chg_now, diff_zero;
  word_t  diff_mark, work_shr;
  logic   grp_final;
  byte_t  grp;
  logic   gen_valid, gen_last;
  byte_t  gen_byte;

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);
  assign adv          = !out_valid || stream.ready;

  assign stream.valid     = out_valid;
  assign stream.out_byte  = out_byte_q;
  assign stream.last_byte = out_last_q;

  assign in_range  = isa_enable && (pc_q > isa_range_low) && (pc_q < isa_range_high);
  assign chg_now   = (tid_q != last_thread);
  assign diff_mark = diff_q | {31'b0, chg_now};
  assign diff_zero = (diff_mark == 32'd0);

  // shared group unit: 7-bit group, final test and shift
  always_comb begin
    if (state == ST_DIFF_VAR) begin
      work_shr  = word_t'($signed(work) >>> 7);
      grp_final = (&work[31:6]) || !(|work[31:6]);
    end else begin
      work_shr  = work >> 7;
      grp_final = !(|work[31:7]);
    end
    grp = {grp_final, work[6:0]};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept) state_next = ST_CLASSIFY;
      ST_CLASSIFY: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (diff_zero)                  state_next = ST_IDLE;
        else if (repeat_count != 32'd0) state_next = ST_REP_MARK;
        else                            state_next = ST_DIFF_VAR;
      end
      ST_REP_MARK: if (adv) state_next = ST_REP_VAR;
      ST_REP_VAR:  if (adv && grp_final) state_next = ST_DIFF_VAR;
      ST_DIFF_VAR: if (adv && grp_final) state_next = thread_chg ? ST_TID_VAR : ST_IDLE;
      ST_TID_VAR:  if (adv && grp_final) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    gen_valid = 1'b0;
    gen_byte  = grp;
    gen_last  = 1'b0;
    work_next = work;
    unique case (state)
      ST_IDLE, ST_CLASSIFY: ;
      ST_DECIDE: work_next = diff_mark;
      ST_REP_MARK: begin
        gen_valid = 1'b1;
        gen_byte  = FINAL_MARK;
        if (adv) work_next = repeat_count;
      end
      ST_REP_VAR: begin
        gen_valid = 1'b1;
        if (adv) work_next = grp_final ? diff_q : work_shr;
      end
      ST_DIFF_VAR: begin
        gen_valid = 1'b1;
        gen_last  = grp_final && !thread_chg;
        if (adv) work_next = grp_final ? tid_q : work_shr;
      end
      ST_TID_VAR: begin
        gen_valid = 1'b1;
        gen_last  = grp_final;
        if (adv) work_next = work_shr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      isa_enable            <= 1'b0;
      isa_range_low         <= '0;
      isa_range_high        <= '0;
      isa_task_source_valid <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ISA_ENABLE:       isa_enable            <= cfg_data[0];
        CFG_ISA_RANGE_LOW:    isa_range_low         <= cfg_data;
        CFG_ISA_RANGE_HIGH:   isa_range_high        <= cfg_data;
        CFG_ISA_TASK_SRC_VLD: isa_task_source_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      last_pc      <= '0;
      last_thread  <= '0;
      repeat_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLASSIFY) last_pc <= pc_q;
      if (state == ST_DECIDE) begin
        if (chg_now) last_thread <= tid_q;
        if (diff_zero) repeat_count <= repeat_count + 32'd1;
      end
      if (state == ST_REP_MARK && adv) repeat_count <= '0;
      if (adv) out_valid <= gen_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pc_q     <= sample.pc & PC_MASK & ~32'd1;
      os_tid_q <= sample.thread_id;
      task_q   <= sample.isa_task;
    end
    if (state == ST_CLASSIFY) begin
      diff_q <= pc_q - last_pc;
      if (in_range)
        tid_q <= isa_task_source_valid ? ISA_TID_BASE + 32'(task_q) : ISA_TID_BASE;
      else
        tid_q <= os_tid_q;
    end
    if (state == ST_DECIDE) begin
      diff_q     <= diff_mark;
      thread_chg <= chg_now;
    end
    work <= work_next;
    if (adv) begin
      out_byte_q <= gen_byte;
      out_last_q <= gen_last;
    end
  end

  a_accept_classify: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CLASSIFY))
    else $error("accepted sample not classified");

  a_repeat_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REP_MARK && adv) |=> (repeat_count == 32'd0))
    else $error("repeat count not cleared after marker");

  a_repeat_silent: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && diff_zero) |=> (state == ST_IDLE && !gen_valid))
    else $error("repeated sample produced output");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (gen_valid && gen_last && adv) |=> (state == ST_IDLE))
    else $error("final byte did not end the sample");

endmodule

/* sim/pcsd_stream_checker.sv */
`timescale 1ns / 100ps

module pcsd_stream_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  pcsd_pkg::cfg_idx_t cfg_index,
  input  pcsd_pkg::word_t    cfg_data,
  pcsd_sample_if             sample,
  pcsd_byte_if               stream,
  output int                 mismatches,
  output int                 backlog
);
  import pcsd_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  eop;
  } beat_t;

  beat_t expected_beats[$];

  logic  isa_en;
  logic  isa_src;
  word_t isa_lo;
  word_t isa_hi;
  word_t prev_pc;
  word_t prev_tid;
  word_t repeat_cnt;
  int    fail_cnt = 0;

  function automatic void push_beat(input byte_t b, inout int n);
    if (n < 16) begin
      expected_beats.push_back('{data: b, eop: 1'b0});
      n++;
    end
  endfunction

  function automatic void push_unsigned(input word_t v, inout int n);
    word_t rest;
    rest = v;
    while ((rest >> 7) != '0) begin
      push_beat({1'b0, rest[6:0]}, n);
      rest = rest >> 7;
    end
    push_beat(FINAL_MARK | {1'b0, rest[6:0]}, n);
  endfunction

  function automatic void push_signed(input word_t v, inout int n);
    word_t rest;
    rest = v;
    while (($signed(rest) >>> 6) != ($signed(rest) >>> 7)) begin
      push_beat({1'b0, rest[6:0]}, n);
      rest = word_t'($signed(rest) >>> 7);
    end
    push_beat(FINAL_MARK | {1'b0, rest[6:0]}, n);
  endfunction

  // bytes that one sample should produce, appended to the expected stream
  function automatic void encode_sample(input word_t raw_pc, input word_t os_tid,
                                        input task_t tsk);
    word_t pc;
    word_t diff;
    word_t tid;
    int    n;
    int    first;
    pc    = raw_pc & PC_MASK & ~word_t'(1);
    diff  = pc - prev_pc;
    n     = 0;
    first = expected_beats.size();
    prev_pc = pc;
    if (isa_en && pc > isa_lo && pc < isa_hi)
      tid = isa_src ? ISA_TID_BASE + word_t'(tsk) : ISA_TID_BASE;
    else
      tid = os_tid;
    if (tid != prev_tid)
      diff[0] = 1'b1;
    if (diff == '0) begin
      repeat_cnt++;
      return;
    end
    if (repeat_cnt != '0) begin
      push_beat(FINAL_MARK, n);
      push_unsigned(repeat_cnt, n);
      repeat_cnt = '0;
    end
    push_signed(diff, n);
    if (diff[0]) begin
      prev_tid = tid;
      push_unsigned(tid, n);
    end
    if (n > 0)
      expected_beats[first + n - 1].eop = 1'b1;
  endfunction

  function automatic void note_failure(input string what, input beat_t want, input beat_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t: %s byte transfer: expected %02h/%0b, got %02h/%0b", $realtime, what,
               want.data, want.eop, got.data, got.eop);
  endfunction

  always @(posedge clk) begin
    beat_t want;
    beat_t got;
    if (rst) begin
      expected_beats.delete();
      isa_en     = 1'b0;
      isa_src    = 1'b0;
      isa_lo     = '0;
      isa_hi     = '0;
      prev_pc    = '0;
      prev_tid   = '0;
      repeat_cnt = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ISA_ENABLE:       isa_en  = cfg_data[0];
          CFG_ISA_RANGE_LOW:    isa_lo  = cfg_data;
          CFG_ISA_RANGE_HIGH:   isa_hi  = cfg_data;
          CFG_ISA_TASK_SRC_VLD: isa_src = cfg_data[0];
          default: ;
        endcase
      end
      // output first: a byte leaving now belongs to an earlier sample
      if (stream.valid && stream.ready) begin
        got = '{data: stream.out_byte, eop: stream.last_byte};
        if (expected_beats.size() == 0) begin
          note_failure("unexpected", '0, got);
        end else begin
          want = expected_beats.pop_front();
          if (want.data !== got.data || want.eop !== got.eop)
            note_failure("wrong", want, got);
        end
      end
      if (sample.valid && sample.ready)
        encode_sample(sample.pc, sample.thread_id, sample.isa_task);
    end
    backlog    <= expected_beats.size();
    mismatches <= fail_cnt;
  end

endmodule

/* sim/pc_sample_delta_compressor_tb.sv */
`timescale 1ns / 100ps

module pc_sample_delta_compressor_tb;
  import pcsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 22;

  logic     clk;
  logic     rst;
  logic     cfg_write;
  cfg_idx_t cfg_index;
  word_t    cfg_data;

  pcsd_sample_if sample();
  pcsd_byte_if   stream();

  int    mismatches;
  int    backlog;
  int    tx_idle_pct;
  int    rx_idle_pct;
  logic  hold_armed;
  word_t last_raw_pc;
  word_t last_raw_tid;
  word_t range_lo;
  word_t range_hi;
  word_t thread_pool[4] = '{32'd1, 32'd2, 32'd100000, 32'hFFFF_FFFF};

  pc_sample_delta_compressor i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .stream    (stream)
  );

  pcsd_stream_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .stream     (stream),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver, with one long hold-off once armed
  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    stream.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        stream.ready <= 1'b0;
        hold_left--;
      end else begin
        stream.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write || (sample.valid && sample.ready) || (stream.valid && stream.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("pc_sample_delta_compressor: mismatch");
    $finish;
  end

  task automatic send_sample(input word_t pc, input word_t tid, input task_t tsk);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid     <= 1'b1;
    sample.pc        <= pc;
    sample.thread_id <= tid;
    sample.isa_task  <= tsk;
    do @(posedge clk); while (!sample.ready);
    last_raw_pc  = pc;
    last_raw_tid = tid;
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input word_t val);
    cfg_write <= 1'b1;
    cfg_index <= cfg_idx_t'(idx);
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic en, input word_t lo, input word_t hi, input logic src);
    drain();
    write_reg(CFG_ISA_ENABLE, word_t'(en));
    write_reg(CFG_ISA_RANGE_LOW, lo);
    write_reg(CFG_ISA_RANGE_HIGH, hi);
    write_reg(CFG_ISA_TASK_SRC_VLD, word_t'(src));
    cfg_write <= 1'b0;
    range_lo = lo;
    range_hi = hi;
  endtask

  // a mix of repeats, short hops, in-range samples and thread switches, with some wild ones
  task automatic run_random(input int count);
    word_t pc;
    word_t tid;
    task_t tsk;
    int    mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(9);
      tsk  = task_t'($urandom);
      pc   = last_raw_pc;
      tid  = last_raw_tid;
      case (mode)
        0, 1: ;
        2, 3, 4: pc = last_raw_pc + word_t'(($urandom_range(400) - 200) * 2);
        5, 6: begin
          if (range_hi - range_lo > 1)
            pc = range_lo + 1 + ($urandom % (range_hi - range_lo - 1));
          else
            pc = $urandom;
        end
        7: begin
          tid = thread_pool[$urandom_range(3)];
          pc  = last_raw_pc + word_t'($urandom_range(4095));
        end
        default: begin
          pc  = $urandom;
          tid = $urandom;
        end
      endcase
      send_sample(pc, tid, tsk);
    end
  endtask

  initial begin
    word_t lo;
    int    burst;
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    sample.valid     = 1'b0;
    sample.pc        = '0;
    sample.thread_id = '0;
    sample.isa_task  = '0;
    tx_idle_pct      = 34;
    rx_idle_pct      = 45;
    hold_armed       = 1'b0;
    last_raw_pc      = '0;
    last_raw_tid     = '0;
    range_lo         = '0;
    range_hi         = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    configure(1'b0, '0, '0, 1'b0);
    send_sample(32'd0, 32'd0, 8'd0);
    send_sample(32'd0, 32'd0, 8'd0);
    send_sample(32'd1, 32'd0, 8'd0);     // bit 0 dropped, still a repeat
    send_sample(32'd4, 32'd0, 8'd0);
    send_sample(32'd130, 32'd0, 8'd0);
    send_sample(32'd192, 32'd0, 8'd0);
    send_sample(32'd128, 32'd0, 8'd0);
    send_sample(32'd62, 32'd0, 8'd0);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_sample(32'd0, 32'd0, 8'd0);
    send_sample(32'h8000_0000, 32'h5555_5555, 8'h55);
    send_sample(32'h7FFF_FFFE, 32'hAAAA_AAAA, 8'hAA);

    configure(1'b1, 32'h1000, 32'h2000, 1'b1);
    send_sample(32'h1000, 32'd7, 8'd0);  // on the lower bound: outside
    send_sample(32'h1002, 32'd7, 8'd0);
    send_sample(32'h1002, 32'd9, 8'd0);  // thread id ignored inside the range
    send_sample(32'h1004, 32'd7, 8'hFF);
    send_sample(32'h1FFE, 32'd7, 8'hFF);
    send_sample(32'h2000, 32'd7, 8'd3);  // on the upper bound: outside

    configure(1'b1, 32'h1000, 32'h2000, 1'b0);
    send_sample(32'h1800, 32'd3, 8'd200);
    configure(1'b1, 32'h3000, 32'h3000, 1'b1);
    send_sample(32'h3000, 32'd3, 8'd1);
    configure(1'b1, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_sample(32'h8000_0000, 32'd5, 8'd1);
    configure(1'b1, 32'h0, 32'hFFFF_FFFF, 1'b1);
    send_sample(32'hFFFF_FFFF, 32'd5, 8'd9);
    send_sample(32'h2, 32'd5, 8'd9);

    lo = $urandom & 32'hFFFF_0000;
    configure(1'b1, lo, lo + $urandom_range(2, 1 << 20), 1'b1);
    burst = $urandom_range(128, 140);
    for (int i = 0; i < burst; i++)
      send_sample(last_raw_pc, last_raw_tid, 8'd0);
    run_random(PHASE_ITEMS);

    tx_idle_pct = 45;
    rx_idle_pct = 34;
    configure(1'b1, 32'h0, 32'hFFFF_FFFF, 1'b0);
    run_random(PHASE_ITEMS);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(1'b1, $urandom, $urandom, 1'b1);
    hold_armed = 1'b1;
    run_random(PHASE_ITEMS);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && backlog == 0)
      $display("pc_sample_delta_compressor: match");
    else
      $display("pc_sample_delta_compressor: mismatch");
    $finish;
  end

endmodule
